@@ rtl/core/lskv_pkg.sv @@
`timescale 1ns / 1ps

package lskv_pkg;

  localparam int CAPACITY_DEF    = 128;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_GET    = 3'd1;
  localparam logic [2:0] OP_ACCESS = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] value_in;
  } lskv_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic [1:0]  status;
    logic [7:0]  entry_count;
  } lskv_rsp_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_MOVE,
    FSM_APPLY
  } lskv_state_t;

endpackage

@@ rtl/core/lskv_store.sv @@
`timescale 1ns / 1ps

module lskv_store import lskv_pkg::*; #(
  parameter int DEPTH       = CAPACITY_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [KEY_WIDTH-1:0]   wr_key,
  input  logic [VALUE_WIDTH-1:0] wr_val,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [KEY_WIDTH-1:0]   rd_key,
  output logic [VALUE_WIDTH-1:0] rd_val
);

  logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  // Read data holds until the next read, so the last scanned pair stays visible.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/lskv_ctrl.sv @@
`timescale 1ns / 1ps

module lskv_ctrl import lskv_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW         = $clog2(CAPACITY),
  localparam int CW         = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lskv_req_t              in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lskv_rsp_t              out_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [KEY_WIDTH-1:0]   wr_key,
  output logic [VALUE_WIDTH-1:0] wr_val,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [KEY_WIDTH-1:0]   rd_key,
  input  logic [VALUE_WIDTH-1:0] rd_val
);

  lskv_state_t            state_r, state_nxt;
  logic [2:0]             op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [AW-1:0]          idx_r;
  logic                   hit_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r;
  lskv_rsp_t              out_data_r, res;

  logic          in_fire, match, scan_last, full, is_ins, out_free, apply_go;
  logic [AW-1:0] last_idx;

  assign in_stall  = (state_r != FSM_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign match     = (rd_key == key_r);
  assign scan_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign last_idx  = AW'(count_r - CW'(1));
  assign full      = (count_r == CW'(CAPACITY));
  assign is_ins    = (op_r == OP_SET) || (op_r == OP_ACCESS);
  assign out_free  = !out_valid_r || !out_stall;
  assign apply_go  = (state_r == FSM_APPLY) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          state_nxt = (count_r == '0) ? FSM_APPLY : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (match) begin
          state_nxt = (op_r == OP_DELETE && idx_r != last_idx) ? FSM_MOVE : FSM_APPLY;
        end else if (scan_last) begin
          state_nxt = FSM_APPLY;
        end
      end
      FSM_MOVE:  state_nxt = FSM_APPLY;
      FSM_APPLY: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default:   state_nxt = FSM_IDLE;
    endcase
  end

  // Reads and writes never meet on one edge: the scan only reads, and the
  // move and the final update only write, so no forwarding path is needed.
  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = idx_r;
    wr_key          = key_r;
    wr_val          = val_r;
    count_nxt       = count_r;
    res.found       = hit_r;
    res.value_out   = '0;
    res.status      = ST_OK;
    res.entry_count = '0;
    unique case (state_r)
      FSM_IDLE: begin
        rd_en = in_fire;
      end
      FSM_SCAN: begin
        if (!match && !scan_last) begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
        end else if (match && op_r == OP_DELETE && idx_r != last_idx) begin
          rd_en   = 1'b1;
          rd_addr = last_idx;
        end
      end
      FSM_MOVE: begin
        // The last pair fills the slot of the deleted key.
        wr_en  = 1'b1;
        wr_key = rd_key;
        wr_val = rd_val;
      end
      FSM_APPLY: begin
        if (is_ins) begin
          if (hit_r) begin
            if (op_r == OP_SET) begin
              wr_en         = out_free;
              res.value_out = 32'(val_r);
            end else begin
              res.value_out = 32'(rd_val);
            end
          end else if (!full) begin
            wr_en     = out_free;
            wr_addr   = AW'(count_r);
            wr_val    = (op_r == OP_SET) ? val_r : '0;
            count_nxt = count_r + CW'(1);
            res.value_out = (op_r == OP_SET) ? 32'(val_r) : '0;
          end else begin
            res.status = ST_FULL;
          end
        end else if (op_r == OP_DELETE) begin
          if (hit_r) begin
            count_nxt = count_r - CW'(1);
          end else begin
            res.status = ST_MISSING;
          end
        end else if (op_r == OP_CLEAR) begin
          count_nxt = '0;
        end else if (hit_r) begin
          res.value_out = 32'(rd_val);
        end else begin
          res.status = ST_MISSING;
        end
      end
      default: ;
    endcase
    res.entry_count = 8'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_data.op;
      key_r <= KEY_WIDTH'(in_data.key);
      val_r <= VALUE_WIDTH'(in_data.value_in);
      hit_r <= 1'b0;
      idx_r <= '0;
    end else if (state_r == FSM_SCAN) begin
      if (match) begin
        hit_r <= 1'b1;
      end else if (!scan_last) begin
        idx_r <= idx_r + AW'(1);
      end
    end
    if (apply_go) begin
      out_data_r <= res;
    end
  end

endmodule

@@ rtl/core/linear_search_key_value_table.sv @@
`timescale 1ns / 1ps
// Channel  Ports                             Direction  Moves
// in       in_valid, in_stall, in_data       input      request item (op, key, value_in)
// out      out_valid, out_stall, out_data    output     result item (found, value, status, count)
//
// An item is accepted in idle, then scans the stored entries up to the first match (every
// entry on a miss; an empty table skips the scan), moves the last pair on a delete that
// needs it, and applies its update while the result is registered, then returns to idle.
// The scan reads one stored key per cycle through the single memory read port.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
// A new item is taken while a finished result waits; a stalled output holds
// the last step of an item until the result register frees.

module linear_search_key_value_table import lskv_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lskv_req_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lskv_rsp_t out_data
);

  localparam int AW = $clog2(CAPACITY);

  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [KEY_WIDTH-1:0]   wr_key, rd_key;
  logic [VALUE_WIDTH-1:0] wr_val, rd_val;

  lskv_ctrl #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_val    (wr_val),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_val    (rd_val)
  );

  lskv_store #(
    .DEPTH       (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_val  (wr_val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

endmodule

@@ rtl/core/lskv_chk.sv @@
`timescale 1ns / 1ps

module lskv_chk import lskv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input lskv_rsp_t out_data
);

  // A stalled result item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // The block works on one item at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while an item is in work");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == ST_OK)
    else $error("key found but status reports a failure");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> !out_data.found && out_data.value_out == '0)
    else $error("full table result carries a key or value");

  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_MISSING |-> out_data.value_out == '0)
    else $error("missing key result carries a value");

endmodule

bind linear_search_key_value_table lskv_chk u_lskv_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ test/lskv_checker.sv @@
`timescale 1ns / 1ps

module lskv_checker import lskv_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  lskv_req_t in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  lskv_rsp_t out_data,
  output int        fail_count,
  output int        answers_pending
);

  logic [31:0] mirror_keys [CAPACITY];
  logic [31:0] mirror_vals [CAPACITY];
  int          mirror_count;
  lskv_rsp_t   awaited_answers [$];
  lskv_rsp_t   want;
  int          mismatches = 0;

  initial begin
    fail_count      = 0;
    answers_pending = 0;
    mirror_count    = 0;
  end

  // First occupied slot holding the key, or -1 when it is absent.
  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < mirror_count; i++) begin
      if (mirror_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one request to the mirrored table and returns the answer it gives.
  function automatic lskv_rsp_t predict_answer(lskv_req_t req);
    int        slot;
    lskv_rsp_t ans;
    slot          = find_key(req.key);
    ans           = '0;
    ans.found     = (slot >= 0);
    ans.status    = ST_OK;
    case (req.op)
      OP_SET, OP_ACCESS: begin
        if (slot >= 0) begin
          if (req.op == OP_SET) mirror_vals[slot] = req.value_in;
          ans.value_out = mirror_vals[slot];
        end else if (mirror_count < CAPACITY) begin
          mirror_keys[mirror_count] = req.key;
          mirror_vals[mirror_count] = (req.op == OP_SET) ? req.value_in : 32'h0;
          ans.value_out = mirror_vals[mirror_count];
          mirror_count++;
        end else begin
          ans.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (slot >= 0) begin
          mirror_keys[slot] = mirror_keys[mirror_count - 1];
          mirror_vals[slot] = mirror_vals[mirror_count - 1];
          mirror_count--;
        end else begin
          ans.status = ST_MISSING;
        end
      end
      OP_CLEAR: begin
        mirror_count = 0;
      end
      default: begin
        // Get, and the spare op codes behave the same way.
        if (slot >= 0) ans.value_out = mirror_vals[slot];
        else ans.status = ST_MISSING;
      end
    endcase
    ans.entry_count = 8'(mirror_count);
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mirror_count = 0;
      awaited_answers.delete();
    end else begin
      if (in_valid && !in_stall) awaited_answers.push_back(predict_answer(in_data));
      if (out_valid && !out_stall) begin
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result item with nothing awaited: found=%0d value=%h status=%0d count=%0d",
                     $time, out_data.found, out_data.value_out, out_data.status,
                     out_data.entry_count);
        end else begin
          want = awaited_answers.pop_front();
          if (out_data.found !== want.found || out_data.value_out !== want.value_out ||
              out_data.status !== want.status || out_data.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected found=%0d value=%h status=%0d count=%0d, got found=%0d value=%h status=%0d count=%0d",
                       $time, want.found, want.value_out, want.status, want.entry_count,
                       out_data.found, out_data.value_out, out_data.status,
                       out_data.entry_count);
          end
        end
      end
    end
    fail_count      <= mismatches;
    answers_pending <= awaited_answers.size();
  end

endmodule

@@ test/tb_linear_search_key_value_table.sv @@
`timescale 1ns / 1ps

module tb_linear_search_key_value_table;
  import lskv_pkg::*;

  localparam int POOL_SIZE   = 200;
  localparam int HOLD_CYCLES = 600;
  localparam int QUIET_LIMIT = 5000;
  localparam int ROUNDS      = 5;
  localparam int FILL_ITEMS  = 170;
  localparam int CHURN_ITEMS = 110;
  localparam int NOISE_ITEMS = 20;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum int {SEG_FILL, SEG_CHURN, SEG_NOISE} seg_kind_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lskv_req_t in_data;
  logic      out_valid;
  logic      out_stall;
  lskv_rsp_t out_data;
  int        fail_count;
  int        answers_pending;

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_asked    = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;
  int          fill_ptr      = 0;
  logic [31:0] key_pool [POOL_SIZE];

  always #2 clk = ~clk;

  linear_search_key_value_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lskv_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .answers_pending (answers_pending)
  );

  // Result side: random stalls, plus long hold-offs asked for by the stimulus.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL linear_search_key_value_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic lskv_req_t req_of(logic [2:0] op, logic [31:0] key, logic [31:0] val);
    lskv_req_t r;
    r.op       = op;
    r.key      = key;
    r.value_in = val;
    return r;
  endfunction

  function automatic logic [31:0] pool_key();
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  task automatic send_item(input lskv_req_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_segment(input seg_kind_t kind, input int n);
    lskv_req_t req;
    int        roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      case (kind)
        SEG_FILL: begin
          // Walk the pool so the table fills up and then overflows.
          if (roll < 80) begin
            req = req_of((roll < 60) ? OP_SET : OP_ACCESS, key_pool[fill_ptr], $urandom);
            fill_ptr = (fill_ptr + 1) % POOL_SIZE;
          end else begin
            req = req_of(OP_GET, pool_key(), $urandom);
          end
        end
        SEG_CHURN: begin
          if (roll < 25)      req = req_of(OP_SET, pool_key(), $urandom);
          else if (roll < 55) req = req_of(OP_GET, pool_key(), $urandom);
          else if (roll < 70) req = req_of(OP_ACCESS, pool_key(), $urandom);
          else if (roll < 95) req = req_of(OP_DELETE, pool_key(), $urandom);
          else if (roll < 99)
            req = req_of(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), pool_key(), $urandom);
          else                req = req_of(OP_CLEAR, pool_key(), $urandom);
        end
        default: begin
          req = req_of(3'($urandom), (roll < 50) ? $urandom : pool_key(), $urandom);
        end
      endcase
      send_item(req);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on an empty table, no idling.
    send_item(req_of(OP_GET,    32'h0000_0000, 32'hFFFF_FFFF));
    send_item(req_of(OP_DELETE, 32'h0000_0000, 32'h0000_0000));
    send_item(req_of(OP_SET,    32'h0000_0000, 32'hFFFF_FFFF));
    send_item(req_of(OP_SET,    32'hFFFF_FFFF, 32'h0000_0000));
    send_item(req_of(OP_SET,    32'h0000_0000, 32'h1234_5678));
    send_item(req_of(OP_GET,    32'h0000_0000, 32'h0000_0000));
    send_item(req_of(OP_ACCESS, 32'hA5A5_A5A5, 32'hFFFF_FFFF));
    send_item(req_of(OP_ACCESS, 32'hFFFF_FFFF, 32'h5A5A_5A5A));
    send_item(req_of(OP_SPARE_LO, 32'h0000_0000, 32'h0000_0000));
    send_item(req_of(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(req_of(OP_SPARE_HI, 32'h0000_0001, 32'h0000_0000));
    // Deleting the first entry moves the last one into its slot.
    send_item(req_of(OP_DELETE, 32'h0000_0000, 32'h0000_0000));
    send_item(req_of(OP_GET,    32'hA5A5_A5A5, 32'h0000_0000));
    send_item(req_of(OP_GET,    32'hFFFF_FFFF, 32'h0000_0000));
    send_item(req_of(OP_GET,    32'h0000_0000, 32'h0000_0000));
    send_item(req_of(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(req_of(OP_SET,    32'h8000_0001, 32'h7FFF_FFFE));
    send_item(req_of(OP_CLEAR,  32'hA5A5_A5A5, 32'h0000_0000));
    send_item(req_of(OP_CLEAR,  32'h0000_0001, 32'hFFFF_FFFF));
    send_item(req_of(OP_GET,    32'hA5A5_A5A5, 32'h0000_0000));
    send_item(req_of(OP_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF));

    for (int r = 0; r < ROUNDS; r++) begin
      case (r)
        1:       begin send_idle_pct = 75; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 75; end
        3:       begin send_idle_pct = 13; stall_pct = 13; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      send_item(req_of(OP_CLEAR, pool_key(), $urandom));
      // The result side holds off while items keep coming, so the block backs up.
      if (r == 0) hold_asked++;
      run_segment(SEG_FILL, FILL_ITEMS);
      run_segment(SEG_CHURN, CHURN_ITEMS);
      run_segment(SEG_NOISE, NOISE_ITEMS);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (answers_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS linear_search_key_value_table");
    end else begin
      $display("FAIL linear_search_key_value_table");
    end
    $finish;
  end

endmodule

@@ linear_search_key_value_table.f @@
rtl/core/lskv_pkg.sv
rtl/core/lskv_store.sv
rtl/core/lskv_ctrl.sv
rtl/core/linear_search_key_value_table.sv
rtl/core/lskv_chk.sv
test/lskv_checker.sv
test/tb_linear_search_key_value_table.sv
